// ===== hdl/lz77_block_decompressor_macros.svh =====
// Assertion macros for the LZ4 block decompressor.
// Used by lz77_block_decompressor.sv; no other dependencies.
`ifndef LZ77_BLOCK_DECOMPRESSOR_MACROS_SVH
`define LZ77_BLOCK_DECOMPRESSOR_MACROS_SVH
`ifndef SYNTH
`define LZ4BD_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("lz4bd assertion failed");
`define LZ4BD_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("lz4bd forbidden condition");
`else
`define LZ4BD_ASSERT(lbl, ck, rn, prop)
`define LZ4BD_NEVER(lbl, ck, rn, cond)
`endif
`endif

// ===== hdl/lz4bd_pkg.sv =====
// Shared constants and helpers of the LZ4 block decompressor.
// No dependencies.
package lz4bd_pkg;
	localparam logic [7:0]  LEN_EXT      = 8'd255;
	localparam logic [3:0]  NIBBLE_EXT   = 4'd15;
	localparam logic [8:0]  MIN_MATCH    = 9'd4;
	localparam logic [8:0]  EXT_MATCH    = 9'd19;
	localparam logic [25:0] END_MARGIN   = 26'd8;
	localparam logic [23:0] SAT24        = 24'hFFFFFF;
	localparam logic        REG_OUT_SIZE = 1'b0;

	function automatic logic [23:0] sat_inc24(input logic [23:0] v);
		return (v == SAT24) ? v : v + 24'd1;
	endfunction
endpackage

// ===== hdl/lz77_block_decompressor.sv =====
// LZ4 block decompressor top level: stream parser, match copy sequencer, APB register.
// Depends on lz4bd_pkg, lz4bd_hist_ram and lz77_block_decompressor_macros.svh.
// One compressed byte enters per word. Header and offset bytes are consumed by
// the parser; a literal byte leaves as a word of one byte. A match is copied
// from the history RAM byte by byte (registered read, then write-back), and
// each group of up to LANES_OUT bytes leaves as one word; no input is taken
// while a copy runs. A stalled output holds the parser. After block end or a
// bad offset, input words are taken and dropped until reset.
`include "lz77_block_decompressor_macros.svh"
module lz77_block_decompressor #(
	parameter int WINDOW_BYTES = 65536,
	parameter int LANES_OUT    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_byte0..out_byte7, byte_count, zero pad
	output logic        m_tlast,   // block_end
	output logic        m_tuser    // bad_offset
);
	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int SW = AW + 2;

	typedef enum logic [3:0] {
		ST_TOKEN, ST_LITEXT, ST_LIT, ST_OFFLO, ST_OFFHI, ST_MEXT,
		ST_CRD, ST_CWR, ST_CEMIT, ST_DONE
	} state_t;

	state_t        st_q, next_ph_q;
	logic [23:0]   out_size_q, lits_q, bp_q;
	logic [3:0]    nib_q, cnt_q;
	logic [15:0]   off_q;
	logic          final_q;
	logic [8:0]    n_q;
	logic [AW-1:0] wr_q, src_q;
	logic [7:0]    lane_q [8];
	logic          ov_q, olast_q, obad_q;
	logic [63:0]   obytes_q;
	logic [3:0]    ocnt_q;

	logic          out_free, acc, ram_we;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [15:0]   off_full;
	logic          off_bad;
	logic          emit;
	logic [24:0]   lsum;
	logic [23:0]   lits_new;
	logic          fin_new;
	logic [SW-1:0] src_t;
	logic [AW-1:0] src_new, wr_inc, src_inc;
	logic [63:0]   lanes_flat;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == lz4bd_pkg::REG_OUT_SIZE) ? {8'd0, out_size_q} : 32'd0;
	assign out_free = !ov_q || m_tready;
	assign s_tready = out_free && (st_q != ST_CRD) && (st_q != ST_CWR) && (st_q != ST_CEMIT);
	assign acc      = s_tvalid && s_tready;

	assign off_full = {s_tdata, off_q[7:0]};
	assign off_bad  = (off_full == '0) || ({8'd0, off_full} > bp_q) ||
		({1'b0, off_full} > 17'(WINDOW_BYTES));
	assign lsum     = {1'b0, lits_q} + {17'd0, s_tdata};
	assign lits_new = (st_q == ST_TOKEN) ? {20'd0, s_tdata[7:4]} :
		(lsum > {1'b0, lz4bd_pkg::SAT24}) ? lz4bd_pkg::SAT24 : lsum[23:0];
	assign fin_new  = ({2'd0, bp_q} + {2'd0, lits_new} + lz4bd_pkg::END_MARGIN) >
		{2'd0, out_size_q};

	assign src_t   = {2'd0, wr_q} + SW'(WINDOW_BYTES) - SW'(off_full);
	assign src_new = (src_t >= SW'(WINDOW_BYTES)) ? AW'(src_t - SW'(WINDOW_BYTES)) : AW'(src_t);
	assign wr_inc  = (wr_q == AW'(WINDOW_BYTES - 1)) ? '0 : wr_q + AW'(1);
	assign src_inc = (src_q == AW'(WINDOW_BYTES - 1)) ? '0 : src_q + AW'(1);

	assign ram_we    = (st_q == ST_CWR) || ((st_q == ST_LIT) && acc);
	assign ram_wdata = (st_q == ST_CWR) ? ram_rdata : s_tdata;

	// a new output word is loaded this cycle
	always_comb begin
		unique case (st_q)
			ST_TOKEN: emit = acc && (s_tdata[7:4] != lz4bd_pkg::NIBBLE_EXT) &&
				(lits_new == '0) && fin_new;
			ST_LITEXT: emit = acc && (s_tdata != lz4bd_pkg::LEN_EXT) &&
				(lits_new == '0) && fin_new;
			ST_LIT:   emit = acc;
			ST_OFFHI: emit = acc && off_bad;
			ST_CEMIT: emit = out_free;
			default:  emit = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			lanes_flat[i*8 +: 8] = lane_q[i];
		end
	end

	lz4bd_hist_ram #(.DEPTH(WINDOW_BYTES), .AW(AW)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (ram_wdata),
		.raddr (src_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_TOKEN;
			next_ph_q  <= ST_TOKEN;
			out_size_q <= '0;
			lits_q     <= '0;
			bp_q       <= '0;
			nib_q      <= '0;
			cnt_q      <= '0;
			off_q      <= '0;
			final_q    <= 1'b0;
			n_q        <= '0;
			wr_q       <= '0;
			src_q      <= '0;
			ov_q       <= 1'b0;
			olast_q    <= 1'b0;
			obad_q     <= 1'b0;
			obytes_q   <= '0;
			ocnt_q     <= '0;
			for (int i = 0; i < 8; i++) begin
				lane_q[i] <= '0;
			end
		end else begin
			if (psel && penable && pwrite && (paddr[2] == lz4bd_pkg::REG_OUT_SIZE)) begin
				out_size_q <= pwdata[23:0];
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_TOKEN, ST_LITEXT: if (acc) begin
					if (st_q == ST_TOKEN) begin
						nib_q <= s_tdata[3:0];
					end
					lits_q  <= lits_new;
					final_q <= fin_new;
					if ((st_q == ST_TOKEN && s_tdata[7:4] == lz4bd_pkg::NIBBLE_EXT) ||
						(st_q == ST_LITEXT && s_tdata == lz4bd_pkg::LEN_EXT)) begin
						st_q <= ST_LITEXT;
					end else if (lits_new != '0) begin
						st_q <= ST_LIT;
					end else if (fin_new) begin
						obytes_q <= '0;
						ocnt_q   <= '0;
						olast_q  <= 1'b1;
						obad_q   <= 1'b0;
						st_q     <= ST_DONE;
					end else begin
						st_q <= ST_OFFLO;
					end
				end
				ST_LIT: if (acc) begin
					wr_q     <= wr_inc;
					bp_q     <= lz4bd_pkg::sat_inc24(bp_q);
					lits_q   <= lits_q - 24'd1;
					obytes_q <= {56'd0, s_tdata};
					ocnt_q   <= 4'd1;
					obad_q   <= 1'b0;
					olast_q  <= (lits_q == 24'd1) && final_q;
					if (lits_q == 24'd1) begin
						st_q <= final_q ? ST_DONE : ST_OFFLO;
					end
				end
				ST_OFFLO: if (acc) begin
					off_q <= {8'd0, s_tdata};
					st_q  <= ST_OFFHI;
				end
				ST_OFFHI: if (acc) begin
					off_q <= off_full;
					if (off_bad) begin
						obytes_q <= '0;
						ocnt_q   <= '0;
						olast_q  <= 1'b1;
						obad_q   <= 1'b1;
						st_q     <= ST_DONE;
					end else begin
						src_q     <= src_new;
						cnt_q     <= '0;
						n_q       <= (nib_q == lz4bd_pkg::NIBBLE_EXT) ? lz4bd_pkg::EXT_MATCH :
							({5'd0, nib_q} + lz4bd_pkg::MIN_MATCH);
						next_ph_q <= (nib_q == lz4bd_pkg::NIBBLE_EXT) ? ST_MEXT : ST_TOKEN;
						st_q      <= ST_CRD;
					end
				end
				ST_MEXT: if (acc) begin
					n_q       <= {1'b0, s_tdata};
					cnt_q     <= '0;
					next_ph_q <= (s_tdata == lz4bd_pkg::LEN_EXT) ? ST_MEXT : ST_TOKEN;
					if (s_tdata == '0) begin
						st_q <= ST_TOKEN;
					end else begin
						st_q <= ST_CRD;
					end
				end
				ST_CRD: begin
					st_q <= ST_CWR;
				end
				ST_CWR: begin
					lane_q[cnt_q[2:0]] <= ram_rdata;
					cnt_q <= cnt_q + 4'd1;
					n_q   <= n_q - 9'd1;
					wr_q  <= wr_inc;
					src_q <= src_inc;
					bp_q  <= lz4bd_pkg::sat_inc24(bp_q);
					st_q  <= ((cnt_q + 4'd1) == 4'(LANES_OUT) || n_q == 9'd1) ? ST_CEMIT : ST_CRD;
				end
				ST_CEMIT: if (out_free) begin
					obytes_q <= lanes_flat;
					ocnt_q   <= cnt_q;
					olast_q  <= 1'b0;
					obad_q   <= 1'b0;
					cnt_q    <= '0;
					for (int i = 0; i < 8; i++) begin
						lane_q[i] <= '0;
					end
					st_q <= (n_q == '0) ? next_ph_q : ST_CRD;
				end
				ST_DONE: ;
				default: st_q <= ST_DONE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {4'd0, ocnt_q, obytes_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = obad_q;

	`LZ4BD_ASSERT(a_bad_is_end, clk, arst_n, (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[67:64] == 4'd0))
	`LZ4BD_ASSERT(a_cnt_max, clk, arst_n, m_tvalid |-> (m_tdata[67:64] <= 4'(LANES_OUT)))
	`LZ4BD_NEVER(a_no_in_copy, clk, arst_n, s_tready && (st_q == ST_CRD || st_q == ST_CWR))
	`LZ4BD_NEVER(a_no_wr_done, clk, arst_n, ram_we && st_q == ST_DONE)
endmodule

// ===== hdl/lz4bd_hist_ram.sv =====
// History window of the LZ4 block decompressor: one write, one registered read.
// No dependencies.
module lz4bd_hist_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
